@@ rtl/wrp_pkg.sv @@
// shared constants, types and the trig lookup of the wireframe rotate/project unit
package wrp_pkg;

  // angle and trig format
  localparam int ANGLE_STEPS    = 128;
  localparam int ANGLE_BITS     = $clog2(ANGLE_STEPS);
  localparam int QUARTER        = ANGLE_STEPS / 4;
  localparam int QIDX_BITS      = $clog2(QUARTER + 1);
  localparam int TRIG_FRAC_BITS = 14;

  // projection and scaling constants
  localparam int PERSP_OFFSET = 'h95;
  localparam int PERSP_DIV    = 'h90;
  localparam int LINE_SHIFT   = 8;
  localparam int LIN_DIV      = 1 << (LINE_SHIFT + TRIG_FRAC_BITS);

  // divider widths: magnitude of numerator, divisor, quotient
  localparam int NUM_W  = 56;
  localparam int DEN_W  = 40;
  localparam int NUMS_W = NUM_W + 1;
  localparam int DENS_W = DEN_W + 1;
  localparam int QUO_W  = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // command codes on the input tuser
  localparam logic [1:0] KIND_PERSP  = 2'd0;
  localparam logic [1:0] KIND_LINEAR = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  // quadrants of the angle index
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [15:0] S16_MAX = 16'sh7fff;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;

  // sine over the first quadrant, Q2.14, one entry per 1/128 turn
  localparam logic signed [15:0] SIN_Q [QUARTER+1] = '{
    16'sd0,     16'sd804,   16'sd1606,  16'sd2404,  16'sd3196,  16'sd3981,
    16'sd4756,  16'sd5520,  16'sd6270,  16'sd7005,  16'sd7723,  16'sd8423,
    16'sd9102,  16'sd9760,  16'sd10394, 16'sd11003, 16'sd11585, 16'sd12140,
    16'sd12665, 16'sd13160, 16'sd13623, 16'sd14053, 16'sd14449, 16'sd14811,
    16'sd15137, 16'sd15426, 16'sd15679, 16'sd15893, 16'sd16069, 16'sd16207,
    16'sd16305, 16'sd16364, 16'sd16384
  };

  // classified operation
  typedef enum logic [1:0] {
    OP_PERSP  = 2'd0,
    OP_LINEAR = 2'd1,
    OP_LINE   = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } trig_t;

  // classified command as it sits in the queue
  typedef struct packed {
    op_t                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] z;
    logic signed [15:0] scale;
    trig_t              rx;
    trig_t              ry;
    trig_t              rz;
    logic [16:0]        lmx;
    logic [16:0]        lmy;
    logic [16:0]        lmaj;
    logic               lnx;
    logic               lny;
    logic [15:0]        ldist;
  } cmd_t;

  // divide request: magnitudes and signs
  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic [DEN_W-1:0] d;
    logic             negx;
    logic             negy;
    logic             dzero;
    logic [15:0]      steps;
  } dreq_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] steps;
    logic               fault;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // sine and cosine of the negated angle
  function automatic trig_t trig_lookup(logic signed [15:0] angle);
    logic [ANGLE_BITS-1:0] idx;
    logic [1:0]            quad;
    logic [QIDX_BITS-1:0]  r;
    logic signed [15:0]    sv;
    logic signed [15:0]    cv;
    trig_t                 t;
    idx  = ANGLE_BITS'(-angle);
    quad = idx[ANGLE_BITS-1 -: 2];
    r    = QIDX_BITS'(idx[ANGLE_BITS-3:0]);
    sv   = SIN_Q[r];
    cv   = SIN_Q[QIDX_BITS'(QUARTER) - r];
    unique case (quad)
      QUAD_0: begin t.s = sv;  t.c = cv;  end
      QUAD_1: begin t.s = cv;  t.c = -sv; end
      QUAD_2: begin t.s = -sv; t.c = -cv; end
      QUAD_3: begin t.s = -cv; t.c = sv;  end
      default: begin t.s = sv; t.c = cv; end
    endcase
    return t;
  endfunction

endpackage

@@ rtl/wrp_front.sv @@
// front end: accepts input words, decodes the kind, looks up trig and sets up lines
module wrp_front (
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [111:0]             s_tdata,
  input  logic [1:0]               s_tuser,
  input  wrp_pkg::queue_status_t   qstat,
  output logic                     push,
  output wrp_pkg::cmd_t            cmd
);
  import wrp_pkg::*;

  logic signed [15:0] x, y, z, ax, ay, az, sc;
  logic signed [15:0] dx, dy;
  logic [16:0]        mx, my;
  op_t                op;

  assign x  = s_tdata[15:0];
  assign y  = s_tdata[31:16];
  assign z  = s_tdata[47:32];
  assign ax = s_tdata[63:48];
  assign ay = s_tdata[79:64];
  assign az = s_tdata[95:80];
  assign sc = s_tdata[111:96];

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;

  // decode the kind
  always_comb begin
    unique case (s_tuser)
      KIND_PERSP:  op = OP_PERSP;
      KIND_LINEAR: op = OP_LINEAR;
      KIND_LINE:   op = OP_LINE;
      default:     op = OP_BAD;
    endcase
  end

  // line differences and magnitudes
  assign dx = ax - x;
  assign dy = ay - y;
  assign mx = dx[15] ? 17'(-17'(dx)) : 17'(dx);
  assign my = dy[15] ? 17'(-17'(dy)) : 17'(dy);

  // build the queued command
  always_comb begin
    cmd.op    = op;
    cmd.x     = x;
    cmd.y     = y;
    cmd.z     = (op == OP_PERSP) ? 17'(17'(z) - 17'(PERSP_OFFSET)) : 17'(z);
    cmd.scale = sc;
    cmd.rx    = trig_lookup(ax);
    cmd.ry    = trig_lookup(ay);
    cmd.rz    = trig_lookup(az);
    cmd.lmx   = mx;
    cmd.lmy   = my;
    cmd.lmaj  = (mx > my) ? mx : my;
    cmd.lnx   = dx[15];
    cmd.lny   = dy[15];
    cmd.ldist = cmd.lmaj[15:0] + 16'd1;
  end

endmodule

@@ rtl/wrp_queue.sv @@
// short command queue between the front end and the back end
module wrp_queue #(
  parameter int DEPTH = wrp_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wrp_pkg::cmd_t          wdata,
  input  logic                   pop,
  output wrp_pkg::cmd_t          rdata,
  output wrp_pkg::queue_status_t qstat
);
  import wrp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign rdata       = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/wrp_rotate.sv @@
// back end, first half: three rotations, scaling and divide setup
module wrp_rotate (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  wrp_pkg::cmd_t  cmd,
  output logic           out_valid,
  output wrp_pkg::dreq_t req
);
  import wrp_pkg::*;

  localparam int STAGES = 9;
  localparam int FB     = TRIG_FRAC_BITS;

  logic [STAGES-1:0] vld;
  cmd_t c1, c2, c3, c4, c5, c6, c7, c8;

  logic signed [31:0] p_yc, p_ys;
  logic signed [32:0] p_zs, p_zc;
  logic signed [31:0] y2, z2, y2_3, y2_4;
  logic signed [31:0] a_xc, a_xs;
  logic signed [47:0] a_zs, a_zc;
  logic signed [31:0] x2, z3, z3_5;
  logic signed [47:0] b_xc, b_ys, b_xs, b_yc;
  logic signed [32:0] xf, yf, zs;
  logic signed [48:0] px, py;
  logic signed [32:0] zd;
  logic signed [NUMS_W-1:0] nx_s, ny_s;
  logic signed [DENS_W-1:0] d_s;
  dreq_t req_next;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];

  // rotation about x: products, then sums
  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= cmd;
      p_yc <= 32'(cmd.y) * 32'(cmd.rx.c);
      p_ys <= 32'(cmd.y) * 32'(cmd.rx.s);
      p_zs <= 33'(cmd.z) * 33'(cmd.rx.s);
      p_zc <= 33'(cmd.z) * 33'(cmd.rx.c);
      c2   <= c1;
      y2   <= 32'(33'(p_yc) - p_zs);
      z2   <= 32'(33'(p_ys) + p_zc);
    end
  end

  // rotation about y
  always_ff @(posedge clk) begin
    if (en) begin
      c3   <= c2;
      y2_3 <= y2;
      a_xc <= 32'(c2.x) * 32'(c2.ry.c);
      a_xs <= 32'(c2.x) * 32'(c2.ry.s);
      a_zs <= 48'(z2) * 48'(c2.ry.s);
      a_zc <= 48'(z2) * 48'(c2.ry.c);
      c4   <= c3;
      y2_4 <= y2_3;
      x2   <= 32'(((49'(a_xc) <<< FB) + 49'(a_zs)) >>> FB);
      z3   <= 32'((49'(a_zc) - (49'(a_xs) <<< FB)) >>> FB);
    end
  end

  // rotation about z, and the projection depth
  always_ff @(posedge clk) begin
    if (en) begin
      c5   <= c4;
      z3_5 <= z3;
      b_xc <= 48'(x2) * 48'(c4.rz.c);
      b_ys <= 48'(y2_4) * 48'(c4.rz.s);
      b_xs <= 48'(x2) * 48'(c4.rz.s);
      b_yc <= 48'(y2_4) * 48'(c4.rz.c);
      c6   <= c5;
      xf   <= 33'((49'(b_xc) - 49'(b_ys)) >>> FB);
      yf   <= 33'((49'(b_xs) + 49'(b_yc)) >>> FB);
      zs   <= 33'(z3_5) + 33'(PERSP_OFFSET << FB);
    end
  end

  // scale factor, then numerator and divisor
  always_ff @(posedge clk) begin
    if (en) begin
      c7 <= c6;
      px <= 49'(xf) * 49'(c6.scale);
      py <= 49'(yf) * 49'(c6.scale);
      zd <= zs;
      c8 <= c7;
      if (c7.op == OP_PERSP) begin
        nx_s <= NUMS_W'(px) * NUMS_W'(PERSP_OFFSET);
        ny_s <= NUMS_W'(py) * NUMS_W'(PERSP_OFFSET);
        d_s  <= DENS_W'(zd) * DENS_W'(PERSP_DIV);
      end else begin
        nx_s <= NUMS_W'(px);
        ny_s <= NUMS_W'(py);
        d_s  <= DENS_W'(LIN_DIV);
      end
    end
  end

  // magnitudes and quotient signs
  always_comb begin
    req_next    = '0;
    req_next.op = c8.op;
    if (c8.op == OP_LINE) begin
      req_next.nx    = NUM_W'(c8.lmx) << LINE_SHIFT;
      req_next.ny    = NUM_W'(c8.lmy) << LINE_SHIFT;
      req_next.d     = DEN_W'(c8.lmaj);
      req_next.negx  = c8.lnx;
      req_next.negy  = c8.lny;
      req_next.steps = c8.ldist;
    end else begin
      req_next.nx    = NUM_W'(nx_s[NUMS_W-1] ? -nx_s : nx_s);
      req_next.ny    = NUM_W'(ny_s[NUMS_W-1] ? -ny_s : ny_s);
      req_next.d     = DEN_W'(d_s[DENS_W-1] ? -d_s : d_s);
      req_next.negx  = nx_s[NUMS_W-1] ^ d_s[DENS_W-1];
      req_next.negy  = ny_s[NUMS_W-1] ^ d_s[DENS_W-1];
      req_next.steps = '0;
    end
    req_next.dzero = (req_next.d == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req <= req_next;
    end
  end

endmodule

@@ rtl/wrp_div.sv @@
// back end, second half: pipelined restoring divide, saturation and output register
module wrp_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  wrp_pkg::dreq_t req,
  output logic           out_valid,
  output wrp_pkg::res_t  res
);
  import wrp_pkg::*;

  typedef struct packed {
    logic signed [15:0] v;
    logic               sat;
  } lane_t;

  logic             vld   [QUO_W+1];
  dreq_t            dq    [QUO_W+1];
  logic [NUM_W-1:0] rem_x [QUO_W+1];
  logic [NUM_W-1:0] rem_y [QUO_W+1];
  logic [QUO_W-1:0] quo_x [QUO_W+1];
  logic [QUO_W-1:0] quo_y [QUO_W+1];
  logic             ov_x  [QUO_W+1];
  logic             ov_y  [QUO_W+1];
  logic [NUM_W-1:0] lim;
  lane_t            lx, ly;
  res_t             res_next;

  // quotient of 32769 or more saturates in any case
  assign lim = (NUM_W'(req.d) << (QUO_W - 1)) + NUM_W'(req.d);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0]    <= req;
      rem_x[0] <= req.nx;
      rem_y[0] <= req.ny;
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      ov_x[0]  <= (req.nx >= lim);
      ov_y[0]  <= (req.ny >= lim);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [NUM_W-1:0] sh;
    logic             ge_x, ge_y;

    assign sh   = NUM_W'(dq[i].d) << (QUO_W - 1 - i);
    assign ge_x = (rem_x[i] >= sh);
    assign ge_y = (rem_y[i] >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[i+1]    <= dq[i];
        ov_x[i+1]  <= ov_x[i];
        ov_y[i+1]  <= ov_y[i];
        rem_x[i+1] <= ge_x ? rem_x[i] - sh : rem_x[i];
        rem_y[i+1] <= ge_y ? rem_y[i] - sh : rem_y[i];
        quo_x[i+1] <= {quo_x[i][QUO_W-2:0], ge_x};
        quo_y[i+1] <= {quo_y[i][QUO_W-2:0], ge_y};
      end
    end
  end

  // apply the sign and clamp to int16
  function automatic lane_t fit_lane(logic [QUO_W-1:0] q, logic neg, logic ov);
    lane_t l;
    l.sat = 1'b0;
    priority if (ov) begin
      l.v   = neg ? S16_MIN : S16_MAX;
      l.sat = 1'b1;
    end else if (neg) begin
      l.v = 16'(17'd0 - {1'b0, q});
    end else if (q[QUO_W-1]) begin
      l.v   = S16_MAX;
      l.sat = 1'b1;
    end else begin
      l.v = q;
    end
    return l;
  endfunction

  assign lx = fit_lane(quo_x[QUO_W], dq[QUO_W].negx, ov_x[QUO_W]);
  assign ly = fit_lane(quo_y[QUO_W], dq[QUO_W].negy, ov_y[QUO_W]);

  // result word by operation
  always_comb begin
    res_next = '0;
    unique case (dq[QUO_W].op)
      OP_PERSP, OP_LINEAR: begin
        if (dq[QUO_W].dzero) begin
          res_next.fault = 1'b1;
        end else begin
          res_next.x     = lx.v;
          res_next.y     = ly.v;
          res_next.fault = lx.sat | ly.sat;
        end
      end
      OP_LINE: begin
        if (!dq[QUO_W].dzero) begin
          res_next.x     = lx.v;
          res_next.y     = ly.v;
          res_next.steps = dq[QUO_W].steps;
        end
      end
      default: begin
        res_next.fault = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/wireframe_rotate_project.sv @@
// top level of the wireframe rotate/project and line-step unit
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  tdata x,y,z,aux_x,aux_y,aux_z,scale; tuser kind
//   m_*       out  m_tvalid / m_tready  tdata out_x,out_y,out_dist; tuser fault
//
// one word per cycle in and out when nothing stalls; from acceptance to m_tvalid a
// word passes the command queue, nine rotate/scale stages and an 18-stage divider
// that resolves one quotient bit in each of its divide steps.
// rst is synchronous and clears the queue and all stage valids.
// a stalled output freezes the whole back end; the front keeps taking words until
// the command queue is full.
module wireframe_rotate_project #(
  parameter int QUEUE_DEPTH = wrp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // x, y, z, aux_x, aux_y, aux_z, scale
  input  logic [1:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // out_x, out_y, out_dist
  output logic         m_tuser    // fault
);
  import wrp_pkg::*;

  queue_status_t qstat;
  logic          push, pop, en;
  cmd_t          cmd_in, cmd_out;
  logic          rot_valid;
  dreq_t         req;
  res_t          res;

  // back end advances whenever the output register is free or being taken
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !qstat.empty;

  wrp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .qstat    (qstat),
    .push     (push),
    .cmd      (cmd_in)
  );

  wrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .pop   (pop),
    .rdata (cmd_out),
    .qstat (qstat)
  );

  wrp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (!qstat.empty),
    .cmd       (cmd_out),
    .out_valid (rot_valid),
    .req       (req)
  );

  wrp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .req       (req),
    .out_valid (m_tvalid),
    .res       (res)
  );

  assign m_tdata = {res.steps, res.y, res.x};
  assign m_tuser = res.fault;

endmodule

@@ tb/tb_top.sv @@
// testbench of the wireframe rotate/project unit: scoreboard, predictor and stream drivers
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wrp_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x, y, z, ax, ay, az, sc;
  } cmd_word_t;

  typedef struct {
    logic signed [15:0] ox, oy, od;
    logic               fault;
  } res_word_t;

  // sine/cosine tables in q14, built the integer taylor way in q30
  longint sin_q14 [ANGLE_STEPS];
  longint cos_q14 [ANGLE_STEPS];

  function automatic longint mulq30(longint a, longint b);
    return longint'((unsigned'(a) * unsigned'(b)) >> 30);
  endfunction

  function automatic longint q30_round(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return (v < 0) ? -m : m;
  endfunction

  task automatic build_trig();
    longint quad, rem, th, x2, st, ss, ct, cs, s, c;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      quad = (4 * i) / ANGLE_STEPS;
      rem = 4 * i - quad * ANGLE_STEPS;
      th = rem * 64'sd1686629713 / ANGLE_STEPS;
      x2 = mulq30(th, th);
      st = th; ss = th; ct = 64'sd1 <<< 30; cs = ct;
      for (int k = 1; k <= 10; k++) begin
        st = mulq30(st, x2) / ((2 * k) * (2 * k + 1));
        ct = mulq30(ct, x2) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          ss -= st; cs -= ct;
        end else begin
          ss += st; cs += ct;
        end
      end
      case (quad)
        0: begin s = ss;  c = cs;  end
        1: begin s = cs;  c = -ss; end
        2: begin s = -ss; c = -cs; end
        default: begin s = -cs; c = ss; end
      endcase
      sin_q14[i] = q30_round(s);
      cos_q14[i] = q30_round(c);
    end
  endtask

  function automatic longint fshift(longint v);
    longint msk;
    msk = (64'sd1 <<< TRIG_FRAC_BITS) - 1;
    if (v >= 0) return v >>> TRIG_FRAC_BITS;
    return -((-v + msk) >>> TRIG_FRAC_BITS);
  endfunction

  function automatic int turn_index(logic signed [15:0] a);
    int m;
    m = (-int'(a)) % ANGLE_STEPS;
    if (m < 0) m += ANGLE_STEPS;
    return m;
  endfunction

  function automatic longint clamp16(longint v, ref logic f);
    if (v > 32767) begin
      f = 1; return 32767;
    end
    if (v < -32768) begin
      f = 1; return -32768;
    end
    return v;
  endfunction

  // expected result of one command word
  function automatic res_word_t transform_result(cmd_word_t w);
    res_word_t r;
    longint one, px, py, pz, s, c, y2, z2, x2, z3, xf, yf, den;
    int i;
    int dx, dy, mx, my;
    logic f;
    f = 0;
    r.ox = 0; r.oy = 0; r.od = 0;
    one = 64'sd1 <<< TRIG_FRAC_BITS;
    if (w.kind == KIND_PERSP || w.kind == KIND_LINEAR) begin
      px = longint'(w.x) * one;
      py = longint'(w.y) * one;
      pz = (longint'(w.z) - ((w.kind == KIND_PERSP) ? PERSP_OFFSET : 0)) * one;
      i = turn_index(w.ax); s = sin_q14[i]; c = cos_q14[i];
      y2 = fshift(py * c - pz * s);
      z2 = fshift(py * s + pz * c);
      i = turn_index(w.ay); s = sin_q14[i]; c = cos_q14[i];
      x2 = fshift(px * c + z2 * s);
      z3 = fshift(z2 * c - px * s);
      i = turn_index(w.az); s = sin_q14[i]; c = cos_q14[i];
      xf = fshift(x2 * c - y2 * s);
      yf = fshift(x2 * s + y2 * c);
      if (w.kind == KIND_PERSP) begin
        den = PERSP_DIV * (z3 + PERSP_OFFSET * one);
        if (den == 0) f = 1;
        else begin
          r.ox = 16'(clamp16(xf * w.sc * PERSP_OFFSET / den, f));
          r.oy = 16'(clamp16(yf * w.sc * PERSP_OFFSET / den, f));
        end
      end else begin
        den = 256 * one;
        r.ox = 16'(clamp16(xf * w.sc / den, f));
        r.oy = 16'(clamp16(yf * w.sc / den, f));
      end
    end else if (w.kind == KIND_LINE) begin
      dx = int'($signed(16'(w.ax - w.x)));
      dy = int'($signed(16'(w.ay - w.y)));
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (mx > my) begin
        r.od = 16'(mx + 1);
        r.oy = 16'((256 * dy) / mx);
        r.ox = (dx < 0) ? -16'sd256 : 16'sd256;
      end else if (dy != 0) begin
        r.od = 16'(my + 1);
        r.ox = 16'((256 * dx) / my);
        r.oy = (dy < 0) ? -16'sd256 : 16'sd256;
      end
    end else begin
      f = 1;
    end
    r.fault = f;
    return r;
  endfunction

  // queue of pending results and their checker
  class result_board;
    res_word_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_command(cmd_word_t w);
      pending.push_back(transform_result(w));
    endfunction

    function void check_result(res_word_t got);
      res_word_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: x=%0d y=%0d d=%0d f=%0b",
                                   got.ox, got.oy, got.od, got.fault);
        return;
      end
      e = pending.pop_front();
      if (got.ox !== e.ox || got.oy !== e.oy || got.od !== e.od || got.fault !== e.fault) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp x=%0d y=%0d d=%0d f=%0b got x=%0d y=%0d d=%0d f=%0b",
                   checked, e.ox, e.oy, e.od, e.fault, got.ox, got.oy, got.od, got.fault);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;  // x, y, z, aux_x, aux_y, aux_z, scale
  logic [1:0]   s_tuser = '0;  // kind
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [47:0]  m_tdata;       // out_x, out_y, out_dist
  logic         m_tuser;       // fault

  wireframe_rotate_project uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  result_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int quiet_cycles = 0;
  int sent = 0;
  int kinds_seen[4] = '{0, 0, 0, 0};

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result('{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser});
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one word and hold it until taken
  task automatic send_cmd(cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= w.kind;
    s_tdata <= {w.sc, w.az, w.ay, w.ax, w.z, w.y, w.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(w);
    kinds_seen[w.kind]++;
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(8)) - 16'sd4;
      3: return 16'($urandom_range(400)) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_word_t random_cmd();
    cmd_word_t w;
    int r;
    r = $urandom_range(99);
    w.kind = (r < 40) ? KIND_PERSP : (r < 75) ? KIND_LINEAR : (r < 97) ? KIND_LINE : OP_BAD;
    w.x = pick16(); w.y = pick16(); w.z = pick16();
    w.ax = pick16(); w.ay = pick16(); w.az = pick16(); w.sc = pick16();
    // modest coordinates keep most transforms out of saturation
    if ($urandom_range(1)) begin
      w.x = 16'($urandom_range(600)) - 16'sd300;
      w.y = 16'($urandom_range(600)) - 16'sd300;
      w.z = 16'($urandom_range(600)) - 16'sd300;
      w.sc = 16'($urandom_range(512));
    end
    // sometimes a line that is short, diagonal or axis aligned
    if (w.kind == KIND_LINE && $urandom_range(2) == 0) begin
      w.ax = w.x + 16'($urandom_range(6)) - 16'sd3;
      w.ay = ($urandom_range(1)) ? w.y : w.y + (w.ax - w.x);
    end
    return w;
  endfunction

  // directed commands
  task automatic directed_part();
    cmd_word_t w;
    w = '{KIND_PERSP, 16'sd10, 16'sd20, 16'sd30, 16'sd0, 16'sd0, 16'sd0, 16'sd256};
    send_cmd(w);
    w.kind = KIND_LINEAR; send_cmd(w);
    w.kind = OP_BAD; send_cmd(w);
    // perspective with z at the offset, no rotation
    w = '{KIND_PERSP, 16'sd5, 16'sd5, 16'sd149, 16'sd0, 16'sd0, 16'sd0, 16'sd100};
    send_cmd(w);
    // saturation both ways
    w = '{KIND_LINEAR, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff};
    send_cmd(w);
    w = '{KIND_PERSP, 16'sh7fff, 16'sh8000, 16'sd150, 16'sd0, 16'sd0, 16'sd0, 16'sh8000};
    send_cmd(w);
    // quarter turns and extreme angles
    w = '{KIND_LINEAR, 16'sd100, -16'sd50, 16'sd25, 16'sd32, 16'sd64, 16'sd96, 16'sd512};
    send_cmd(w);
    w = '{KIND_PERSP, -16'sd100, 16'sd50, 16'sh8000, 16'sh8000, 16'sh7fff, -16'sd1, 16'sd300};
    send_cmd(w);
    w = '{KIND_LINEAR, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd1, 16'sh8000};
    send_cmd(w);
    // line steps: zero length, x major, y major, tie, wrap, extremes
    w = '{KIND_LINE, 16'sd7, 16'sd7, 16'sd0, 16'sd7, 16'sd7, 16'sd0, 16'sd0};
    send_cmd(w);
    w.ax = 16'sd17; w.ay = 16'sd10; send_cmd(w);
    w.ax = 16'sd1; w.ay = -16'sd20; send_cmd(w);
    w.ax = 16'sd12; w.ay = 16'sd12; send_cmd(w);
    w.ax = -16'sd5; w.ay = 16'sd7; send_cmd(w);
    w = '{KIND_LINE, 16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sd3, 16'sd0, 16'sd0};
    send_cmd(w);
    w = '{KIND_LINE, 16'sd0, 16'sh8000, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
    send_cmd(w);
    w = '{KIND_LINE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
    send_cmd(w);
  endtask

  initial begin
    build_trig();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_part();
    // sender idles lightly, receiver heavily
    send_idle_pct = 8; recv_idle_pct = 69;
    repeat (350) send_cmd(random_cmd());
    // long receiver hold-off while words keep coming
    hold_off <= 300;
    repeat (40) send_cmd(random_cmd());
    // sender pauses until all results are back
    drain();
    send_idle_pct = 69; recv_idle_pct = 8;
    repeat (350) send_cmd(random_cmd());
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (450) send_cmd(random_cmd());
    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d words (persp %0d, linear %0d, line %0d, bad %0d), checked %0d",
             sent, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d left over", board.errors, board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
